/* rtl/jsu_pkg.sv */
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types and codes for the JSON string unescaper: word formats,
// event and error codes, and the command word passed from parser to emitter.
// ----------------------------------------------------------------------------
package jsu_pkg;

    // Default depth of the command queue between parser and emitter
    localparam int JSU_QDEPTH = 4;

    // Result event codes
    localparam logic [1:0] EV_DATA  = 2'd0;
    localparam logic [1:0] EV_CLOSE = 2'd1;
    localparam logic [1:0] EV_ERROR = 2'd2;

    // Error codes
    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_EXP_STRING = 3'd1;
    localparam logic [2:0] ERR_UNTERM     = 3'd2;
    localparam logic [2:0] ERR_BAD_ESC    = 3'd3;
    localparam logic [2:0] ERR_BAD_HEX    = 3'd4;

    // Command operations
    localparam logic [1:0] CMD_BYTE  = 2'd0;
    localparam logic [1:0] CMD_CLOSE = 2'd1;
    localparam logic [1:0] CMD_ERROR = 2'd2;
    localparam logic [1:0] CMD_CODE  = 2'd3;

    // Input word
    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_input;
    } in_word_t;

    // Result word
    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] event_res;
        logic [2:0] error_code;
        logic       last;
    } out_word_t;

    // Command word: one per input that yields results
    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] code;
        logic [2:0]  err;
    } cmd_t;

endpackage

/* rtl/jsu_front.sv */
// ----------------------------------------------------------------------------
// jsu_front
// Parser: accepts source bytes, tracks string, escape, hex and comment
// state, and pushes one command per byte that yields results.
// ----------------------------------------------------------------------------
module jsu_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  jsu_pkg::in_word_t s_data,
    input  logic              q_full,
    output logic              push,
    output jsu_pkg::cmd_t     push_cmd
);
    import jsu_pkg::*;

    localparam logic [2:0] M_IDLE    = 3'd0;
    localparam logic [2:0] M_SLASH   = 3'd1;
    localparam logic [2:0] M_COMMENT = 3'd2;
    localparam logic [2:0] M_STRING  = 3'd3;
    localparam logic [2:0] M_ESC     = 3'd4;
    localparam logic [2:0] M_HEX     = 3'd5;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    logic [2:0]  mode_reg,  mode_next;
    logic [1:0]  hcnt_reg,  hcnt_next;
    logic [15:0] code_reg,  code_next;

    logic        accept;
    logic        eoi;
    logic [7:0]  c;
    logic        hex_ok;
    logic [3:0]  hex_val;
    logic [15:0] code_shift;
    logic        emit;
    cmd_t        cmd;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign c       = s_data.in_byte;
    assign eoi     = s_data.end_of_input || (c == 8'h00);

    // Decode one hex digit, either case
    always_comb begin
        hex_ok  = 1'b1;
        hex_val = 4'd0;
        if (c >= "0" && c <= "9") begin
            hex_val = 4'(c - "0");
        end else if (c >= "a" && c <= "f") begin
            hex_val = 4'(c - "a" + 8'd10);
        end else if (c >= "A" && c <= "F") begin
            hex_val = 4'(c - "A" + 8'd10);
        end else begin
            hex_ok = 1'b0;
        end
    end

    assign code_shift = {code_reg[11:0], hex_val};

    // Classify the byte and compute next parser state
    always_comb begin
        mode_next = mode_reg;
        hcnt_next = hcnt_reg;
        code_next = code_reg;
        emit      = 1'b0;
        cmd       = '{op: CMD_ERROR, code: 16'd0, err: ERR_NONE};
        case (mode_reg)
            M_SLASH: begin
                if (!eoi && c == CH_SLASH) begin
                    mode_next = M_COMMENT;
                end else begin
                    emit      = 1'b1;
                    cmd.err   = ERR_EXP_STRING;
                    mode_next = M_IDLE;
                end
            end
            M_COMMENT: begin
                if (eoi) begin
                    emit      = 1'b1;
                    cmd.err   = ERR_EXP_STRING;
                    mode_next = M_IDLE;
                end else if (c == CH_LF) begin
                    mode_next = M_IDLE;
                end
            end
            M_STRING: begin
                if (eoi) begin
                    emit      = 1'b1;
                    cmd.err   = ERR_UNTERM;
                    mode_next = M_IDLE;
                end else if (c == CH_QUOTE) begin
                    emit      = 1'b1;
                    cmd.op    = CMD_CLOSE;
                    mode_next = M_IDLE;
                end else if (c == CH_BSLASH) begin
                    mode_next = M_ESC;
                end else begin
                    emit     = 1'b1;
                    cmd.op   = CMD_BYTE;
                    cmd.code = {8'd0, c};
                end
            end
            M_ESC: begin
                emit      = 1'b1;
                cmd.op    = CMD_BYTE;
                mode_next = M_STRING;
                case (c)
                    CH_QUOTE:  cmd.code = {8'd0, CH_QUOTE};
                    CH_BSLASH: cmd.code = {8'd0, CH_BSLASH};
                    CH_SLASH:  cmd.code = {8'd0, CH_SLASH};
                    "n":       cmd.code = {8'd0, CH_LF};
                    "t":       cmd.code = {8'd0, CH_TAB};
                    "r":       cmd.code = {8'd0, CH_CR};
                    "b":       cmd.code = {8'd0, CH_BS};
                    "f":       cmd.code = {8'd0, CH_FF};
                    "u": begin
                        emit      = 1'b0;
                        mode_next = M_HEX;
                        hcnt_next = 2'd0;
                        code_next = 16'd0;
                    end
                    default: begin
                        cmd.op    = CMD_ERROR;
                        cmd.err   = ERR_BAD_ESC;
                        mode_next = M_IDLE;
                    end
                endcase
                // end of input wins over any byte match
                if (eoi) begin
                    emit      = 1'b1;
                    cmd.op    = CMD_ERROR;
                    cmd.code  = 16'd0;
                    cmd.err   = ERR_BAD_ESC;
                    mode_next = M_IDLE;
                    hcnt_next = hcnt_reg;
                    code_next = code_reg;
                end
            end
            M_HEX: begin
                if (eoi || !hex_ok) begin
                    emit      = 1'b1;
                    cmd.err   = ERR_BAD_HEX;
                    mode_next = M_IDLE;
                end else if (hcnt_reg == 2'd3) begin
                    emit      = 1'b1;
                    cmd.op    = CMD_CODE;
                    cmd.code  = code_shift;
                    mode_next = M_STRING;
                    hcnt_next = 2'd0;
                    code_next = 16'd0;
                end else begin
                    code_next = code_shift;
                    hcnt_next = hcnt_reg + 2'd1;
                end
            end
            default: begin
                mode_next = M_IDLE;
                if (eoi) begin
                    emit    = 1'b1;
                    cmd.err = ERR_EXP_STRING;
                end else if (c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR) begin
                    mode_next = M_IDLE;
                end else if (c == CH_SLASH) begin
                    mode_next = M_SLASH;
                end else if (c == CH_QUOTE) begin
                    mode_next = M_STRING;
                end else begin
                    emit    = 1'b1;
                    cmd.err = ERR_EXP_STRING;
                end
            end
        endcase
        // every error drops the escape state
        if (emit && cmd.op == CMD_ERROR) begin
            hcnt_next = 2'd0;
            code_next = 16'd0;
        end
    end

    assign push     = accept && emit;
    assign push_cmd = cmd;

    // Advance parser state on each accepted word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= M_IDLE;
            hcnt_reg <= 2'd0;
            code_reg <= 16'd0;
        end else if (accept) begin
            mode_reg <= mode_next;
            hcnt_reg <= hcnt_next;
            code_reg <= code_next;
        end
    end

endmodule

/* rtl/jsu_queue.sv */
// ----------------------------------------------------------------------------
// jsu_queue
// Short command queue between parser and emitter so each side stalls on
// its own.
// ----------------------------------------------------------------------------
module jsu_queue #(
    parameter int DEPTH = jsu_pkg::JSU_QDEPTH
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  jsu_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          head_valid,
    output jsu_pkg::cmd_t head
);
    import jsu_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cmd_t          mem [DEPTH];
    logic [PW-1:0] wptr_reg, wptr_next;
    logic [PW-1:0] rptr_reg, rptr_next;
    logic [CW-1:0] cnt_reg,  cnt_next;
    logic          do_push, do_pop;

    assign full       = (cnt_reg == CW'(DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head       = mem[rptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // Advance pointers with wrap at the queue depth
    always_comb begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (do_push) begin
            wptr_next = (wptr_reg == PW'(DEPTH - 1)) ? '0 : wptr_reg + PW'(1);
        end
        if (do_pop) begin
            rptr_next = (rptr_reg == PW'(DEPTH - 1)) ? '0 : rptr_reg + PW'(1);
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + CW'(1);
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Store the command word
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wptr_reg] <= push_cmd;
        end
    end

endmodule

/* rtl/jsu_back.sv */
// ----------------------------------------------------------------------------
// jsu_back
// Emitter: expands each command into one to three result words and holds
// them in an output register.
// ----------------------------------------------------------------------------
module jsu_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               head_valid,
    input  jsu_pkg::cmd_t      head,
    output logic               pop,
    output logic               m_valid,
    input  logic               m_ready,
    output jsu_pkg::out_word_t m_data
);
    import jsu_pkg::*;

    logic [1:0] idx_reg, idx_next;
    logic       m_valid_reg, m_valid_next;
    out_word_t  m_data_reg, m_data_next;
    logic       load;
    logic [1:0] nres;
    out_word_t  res;

    assign load = head_valid && (!m_valid_reg || m_ready);

    // Build the result word for the current slot of the head command
    always_comb begin
        res  = '{out_byte: 8'd0, event_res: EV_DATA, error_code: ERR_NONE, last: 1'b0};
        nres = 2'd1;
        case (head.op)
            CMD_BYTE: begin
                res.out_byte = head.code[7:0];
            end
            CMD_CLOSE: begin
                res.event_res = EV_CLOSE;
            end
            CMD_ERROR: begin
                res.event_res  = EV_ERROR;
                res.error_code = head.err;
            end
            default: begin
                if (head.code <= 16'h007F) begin
                    nres = 2'd1;
                end else if (head.code <= 16'h07FF) begin
                    nres = 2'd2;
                end else begin
                    nres = 2'd3;
                end
                case (idx_reg)
                    2'd0: begin
                        if (nres == 2'd1) begin
                            res.out_byte = head.code[7:0];
                        end else if (nres == 2'd2) begin
                            res.out_byte = 8'hC0 | {3'd0, head.code[10:6]};
                        end else begin
                            res.out_byte = 8'hE0 | {4'd0, head.code[15:12]};
                        end
                    end
                    2'd1: begin
                        if (nres == 2'd2) begin
                            res.out_byte = 8'h80 | {2'd0, head.code[5:0]};
                        end else begin
                            res.out_byte = 8'h80 | {2'd0, head.code[11:6]};
                        end
                    end
                    default: begin
                        res.out_byte = 8'h80 | {2'd0, head.code[5:0]};
                    end
                endcase
            end
        endcase
        res.last = (idx_reg == nres - 2'd1);
    end

    assign pop = load && res.last;

    // Advance slot index, hold output until taken
    always_comb begin
        idx_next     = idx_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (load) begin
            m_valid_next = 1'b1;
            m_data_next  = res;
            idx_next     = res.last ? 2'd0 : idx_reg + 2'd1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg     <= 2'd0;
            m_valid_reg <= 1'b0;
        end else begin
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

/* rtl/json_string_unescape_utf8_top.sv */
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_top
// Streaming JSON string unescaper: source bytes in, decoded UTF-8 bytes,
// close and error events out.
//
//   Channel | Ports              | Word
//   --------+--------------------+---------------------------------------
//   input   | s_valid/s_ready    | s_data: in_byte, end_of_input
//   result  | m_valid/m_ready    | m_data: out_byte, event_res,
//           |                    |         error_code, last
//
// One input word per cycle while the queue has room, each giving 0 to 3
// result words; the emitter sends one per cycle while m_ready is high, so
// a \u escape above 0x7F holds it for two or three bytes. The queue
// (QDEPTH entries) absorbs those bursts ahead of the output register;
// input stalls only while it is full. Reset is synchronous, active low,
// and returns the parser to idle between strings with the queue empty.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8_top #(
    parameter int QDEPTH = jsu_pkg::JSU_QDEPTH
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  jsu_pkg::in_word_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output jsu_pkg::out_word_t m_data
);
    import jsu_pkg::*;

    logic q_full;
    logic push;
    cmd_t push_cmd;
    logic pop;
    logic head_valid;
    cmd_t head;

    jsu_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .q_full   (q_full),
        .push     (push),
        .push_cmd (push_cmd)
    );

    jsu_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    jsu_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

`ifndef NO_ASSERTIONS
    // Output register is empty right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // Error and close events are single-word results
    a_event_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.event_res == EV_ERROR || m_data.event_res == EV_CLOSE)
        |-> m_data.last && m_data.out_byte == 8'd0)
        else $error("error or close word not marked last or carries a byte");

    // Error code is set exactly on error events
    a_err_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_data.event_res == EV_ERROR) == (m_data.error_code != ERR_NONE)))
        else $error("error code does not match event");

    // Input stalls only when the command queue is full
    a_ready_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> q_full && !push)
        else $error("input stalled with room in the queue");
`endif

endmodule

/* tb/json_string_unescape_utf8_top_tb.sv */
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_top_tb
// Self-checking bench for the JSON string unescaper. A short directed table
// covers the error paths, one- and three-byte UTF-8 and the escaped zero.
// A random part follows, mostly well-formed strings with some broken ones
// mixed in. Every accepted input word runs through a behavioral decoder.
// Each result word is compared with the oldest expected word.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import jsu_pkg::*;

    localparam int RAND_ITEMS = 340;
    localparam int CALM_ITEMS = 60;
    localparam int HOLD_CYCLES = 60;

    // Source characters
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_LOW_A = 8'h61;
    localparam logic [7:0] CH_LOW_B = 8'h62;
    localparam logic [7:0] CH_LOW_F = 8'h66;
    localparam logic [7:0] CH_LOW_G = 8'h67;
    localparam logic [7:0] CH_LOW_N = 8'h6E;
    localparam logic [7:0] CH_LOW_Q = 8'h71;
    localparam logic [7:0] CH_LOW_R = 8'h72;
    localparam logic [7:0] CH_LOW_T = 8'h74;
    localparam logic [7:0] CH_LOW_U = 8'h75;
    localparam logic [7:0] CH_UP_F  = 8'h46;
    localparam logic [7:0] CH_ZERO  = 8'h30;

    typedef enum logic [2:0] {
        PS_IDLE, PS_SLASH, PS_COMMENT, PS_STRING, PS_ESC, PS_HEX
    } parse_mode_t;

    typedef struct packed {
        in_word_t  w;
        logic      typed;
        out_word_t r;
    } stim_row_t;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_word_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_word_t m_data;

    json_string_unescape_utf8_top dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #5 aclk = ~aclk;

    // Decoder state
    parse_mode_t pmode = PS_IDLE;
    logic [1:0]  hex_seen = 2'd0;
    logic [15:0] code_pt = 16'd0;
    out_word_t   step_res [3];
    int          step_n;

    stim_row_t   stim_q [$];
    out_word_t   want_q [$];
    stim_row_t   cur_row = '0;
    int          n_dir;
    int          n_in = 0;
    int          mismatches = 0;
    logic        calm = 1'b0;
    logic        stim_done = 1'b0;
    logic [7:0]  esc_chars [8] = '{CH_QUOTE, CH_BSL, CH_SLASH, CH_LOW_N,
                                   CH_LOW_T, CH_LOW_R, CH_LOW_B, CH_LOW_F};

    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) return {1'b0, c[3:0]};
        if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
            return {1'b0, c[3:0] + 4'd9};
        return 5'h10;
    endfunction

    function automatic out_word_t err_word(input logic [2:0] code);
        return '{8'h00, EV_ERROR, code, 1'b1};
    endfunction

    task automatic put_res(input logic [7:0] b, input logic [1:0] ev);
        step_res[step_n] = '{b, ev, ERR_NONE, 1'b0};
        step_n++;
    endtask

    // Decode one source word into step_res / step_n and advance the state
    task automatic unescape_step(input in_word_t w);
        logic [7:0]  c;
        logic        fin;
        logic [4:0]  hv;
        logic [2:0]  err;
        c = w.in_byte;
        fin = w.end_of_input || (c == CH_NUL);
        step_n = 0;
        err = ERR_NONE;
        case (pmode)
            PS_SLASH: begin
                if (!fin && c == CH_SLASH) pmode = PS_COMMENT;
                else err = ERR_EXP_STRING;
            end
            PS_COMMENT: begin
                if (fin) err = ERR_EXP_STRING;
                else if (c == CH_LF) pmode = PS_IDLE;
            end
            PS_STRING: begin
                if (fin) begin
                    err = ERR_UNTERM;
                end else if (c == CH_QUOTE) begin
                    put_res(8'h00, EV_CLOSE);
                    pmode = PS_IDLE;
                end else if (c == CH_BSL) begin
                    pmode = PS_ESC;
                end else begin
                    put_res(c, EV_DATA);
                end
            end
            PS_ESC: begin
                if (fin) begin
                    err = ERR_BAD_ESC;
                end else begin
                    case (c)
                        CH_QUOTE, CH_BSL, CH_SLASH: put_res(c, EV_DATA);
                        CH_LOW_N: put_res(8'h0A, EV_DATA);
                        CH_LOW_T: put_res(8'h09, EV_DATA);
                        CH_LOW_R: put_res(8'h0D, EV_DATA);
                        CH_LOW_B: put_res(8'h08, EV_DATA);
                        CH_LOW_F: put_res(8'h0C, EV_DATA);
                        CH_LOW_U: begin
                            pmode = PS_HEX;
                            hex_seen = 2'd0;
                            code_pt = 16'd0;
                        end
                        default: err = ERR_BAD_ESC;
                    endcase
                    if (step_n > 0) pmode = PS_STRING;
                end
            end
            PS_HEX: begin
                hv = hex_nibble(c);
                if (fin || hv[4]) begin
                    err = ERR_BAD_HEX;
                end else begin
                    code_pt = {code_pt[11:0], hv[3:0]};
                    if (hex_seen == 2'd3) begin
                        // Encode the code point as one to three UTF-8 bytes
                        if (code_pt <= 16'h007F) begin
                            put_res(code_pt[7:0], EV_DATA);
                        end else if (code_pt <= 16'h07FF) begin
                            put_res(8'hC0 | {3'b000, code_pt[10:6]}, EV_DATA);
                            put_res(8'h80 | {2'b00, code_pt[5:0]}, EV_DATA);
                        end else begin
                            put_res(8'hE0 | {4'h0, code_pt[15:12]}, EV_DATA);
                            put_res(8'h80 | {2'b00, code_pt[11:6]}, EV_DATA);
                            put_res(8'h80 | {2'b00, code_pt[5:0]}, EV_DATA);
                        end
                        hex_seen = 2'd0;
                        code_pt = 16'd0;
                        pmode = PS_STRING;
                    end else begin
                        hex_seen = hex_seen + 2'd1;
                    end
                end
            end
            default: begin
                pmode = PS_IDLE;
                if (fin) err = ERR_EXP_STRING;
                else if (c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR) ;
                else if (c == CH_SLASH) pmode = PS_SLASH;
                else if (c == CH_QUOTE) pmode = PS_STRING;
                else err = ERR_EXP_STRING;
            end
        endcase
        // Any error replaces the results and drops back to idle
        if (err != ERR_NONE) begin
            step_res[0] = err_word(err);
            step_n = 1;
            pmode = PS_IDLE;
            hex_seen = 2'd0;
            code_pt = 16'd0;
        end
        if (step_n > 0) step_res[step_n - 1].last = 1'b1;
    endtask

    // Stimulus builders
    task automatic add(input logic [7:0] b, input logic eoi);
        stim_q.push_back('{'{b, eoi}, 1'b0, out_word_t'('0)});
    endtask

    task automatic add_t(input logic [7:0] b, input logic eoi, input out_word_t r);
        stim_q.push_back('{'{b, eoi}, 1'b1, r});
    endtask

    // End the source: flagged end with a random ignored byte, or a zero byte
    task automatic add_end();
        if ($urandom_range(0, 1)) add(8'($urandom_range(0, 255)), 1'b1);
        else add(CH_NUL, 1'b0);
    endtask

    task automatic add_hex_digit(input logic [3:0] n);
        if (n < 4'd10) add(CH_ZERO + {4'h0, n}, 1'b0);
        else if ($urandom_range(0, 1)) add(8'h41 + {4'h0, n} - 8'd10, 1'b0);
        else add(8'h61 + {4'h0, n} - 8'd10, 1'b0);
    endtask

    // One piece of string content: plain byte, short escape or \u escape
    task automatic add_piece();
        logic [7:0]  c;
        logic [15:0] cp;
        case ($urandom_range(0, 5))
            0, 1, 2: begin
                do c = 8'($urandom_range(1, 255));
                while (c == CH_QUOTE || c == CH_BSL);
                add(c, 1'b0);
            end
            3: begin
                add(CH_BSL, 1'b0);
                add(esc_chars[$urandom_range(0, 7)], 1'b0);
            end
            default: begin
                case ($urandom_range(0, 2))
                    0: cp = 16'($urandom_range(0, 16'h007F));
                    1: cp = 16'($urandom_range(16'h0080, 16'h07FF));
                    default: cp = 16'($urandom_range(16'h0800, 16'hFFFF));
                endcase
                add(CH_BSL, 1'b0);
                add(CH_LOW_U, 1'b0);
                for (int k = 3; k >= 0; k--) add_hex_digit(cp[4*k +: 4]);
            end
        endcase
    endtask

    task automatic build_random();
        logic [7:0] c;
        logic [4:0] hv;
        int         kind;
        while (stim_q.size() - n_dir < RAND_ITEMS) begin
            if ($urandom_range(0, 9) < 7) begin
                // Well-formed string, with optional whitespace and comment first
                repeat ($urandom_range(0, 2)) begin
                    case ($urandom_range(0, 3))
                        0: add(CH_SPACE, 1'b0);
                        1: add(CH_TAB, 1'b0);
                        2: add(CH_LF, 1'b0);
                        default: add(CH_CR, 1'b0);
                    endcase
                end
                if ($urandom_range(0, 7) == 0) begin
                    add(CH_SLASH, 1'b0);
                    add(CH_SLASH, 1'b0);
                    repeat ($urandom_range(0, 3)) begin
                        do c = 8'($urandom_range(1, 255));
                        while (c == CH_LF);
                        add(c, 1'b0);
                    end
                    add(CH_LF, 1'b0);
                end
                add(CH_QUOTE, 1'b0);
                repeat ($urandom_range(0, 6)) add_piece();
                add(CH_QUOTE, 1'b0);
            end else begin
                kind = $urandom_range(0, 5);
                case (kind)
                    0: add(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                    1: begin
                        add(CH_QUOTE, 1'b0);
                        repeat ($urandom_range(0, 3)) add_piece();
                        add_end();
                    end
                    2: begin
                        add(CH_QUOTE, 1'b0);
                        repeat ($urandom_range(0, 2)) add_piece();
                        add(CH_BSL, 1'b0);
                        if ($urandom_range(0, 3) == 0) begin
                            add_end();
                        end else begin
                            do c = 8'($urandom_range(1, 255));
                            while (c == CH_LOW_U || c inside {esc_chars});
                            add(c, 1'b0);
                        end
                    end
                    3: begin
                        add(CH_QUOTE, 1'b0);
                        add(CH_BSL, 1'b0);
                        add(CH_LOW_U, 1'b0);
                        repeat ($urandom_range(0, 3))
                            add_hex_digit(4'($urandom_range(0, 15)));
                        if ($urandom_range(0, 3) == 0) begin
                            add_end();
                        end else begin
                            do begin
                                c = 8'($urandom_range(0, 255));
                                hv = hex_nibble(c);
                            end while (!hv[4]);
                            add(c, 1'b0);
                        end
                    end
                    4: begin
                        add(CH_SLASH, 1'b0);
                        if ($urandom_range(0, 3) == 0) begin
                            add_end();
                        end else begin
                            do c = 8'($urandom_range(0, 255));
                            while (c == CH_SLASH);
                            add(c, 1'b0);
                        end
                    end
                    default: begin
                        add(CH_SLASH, 1'b0);
                        add(CH_SLASH, 1'b0);
                        repeat ($urandom_range(0, 3)) begin
                            do c = 8'($urandom_range(1, 255));
                            while (c == CH_LF);
                            add(c, 1'b0);
                        end
                        add_end();
                    end
                endcase
            end
        end
    endtask

    // Directed table, then the random part
    initial begin
        add_t(8'hA5, 1'b1, err_word(ERR_EXP_STRING));     // end of input in idle
        add(CH_SLASH, 1'b0);
        add(CH_SLASH, 1'b0);
        add(8'hFF, 1'b0);
        add_t(8'h00, 1'b1, err_word(ERR_EXP_STRING));     // end inside a comment
        add(CH_SLASH, 1'b0);
        add_t(CH_LOW_A, 1'b0, err_word(ERR_EXP_STRING));  // lone slash
        add(CH_QUOTE, 1'b0);
        add(8'hFF, 1'b0);
        add(CH_BSL, 1'b0);
        add(CH_LOW_U, 1'b0);
        add(CH_UP_F, 1'b0);
        add(CH_LOW_F, 1'b0);
        add(CH_UP_F, 1'b0);
        add(CH_LOW_F, 1'b0);                              // U+FFFF, three bytes
        add(CH_BSL, 1'b0);
        add(CH_LOW_U, 1'b0);
        repeat (3) add(CH_ZERO, 1'b0);
        add_t(CH_ZERO, 1'b0, '{8'h00, EV_DATA, ERR_NONE, 1'b1}); // escaped zero
        add(CH_BSL, 1'b0);
        add_t(CH_LOW_Q, 1'b0, err_word(ERR_BAD_ESC));     // unknown escape
        add(CH_QUOTE, 1'b0);
        add(CH_BSL, 1'b0);
        add(CH_LOW_U, 1'b0);
        add_t(CH_LOW_G, 1'b0, err_word(ERR_BAD_HEX));     // non-hex digit
        add(CH_QUOTE, 1'b0);
        add_t(CH_NUL, 1'b0, err_word(ERR_UNTERM));        // zero byte in string
        add(CH_QUOTE, 1'b0);
        add(CH_BSL, 1'b0);
        add_t(8'h5A, 1'b1, err_word(ERR_BAD_ESC));        // end after backslash
        add(CH_QUOTE, 1'b0);
        add_t(CH_QUOTE, 1'b0, '{8'h00, EV_CLOSE, ERR_NONE, 1'b1});
        n_dir = stim_q.size();
        build_random();
    end

    // Reset
    initial begin
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
    end

    // Source side: offer words at the falling edge, idle in short bursts
    initial begin
        wait (aresetn);
        @(negedge aclk);
        for (int i = 0; i < stim_q.size(); i++) begin
            calm = (i >= stim_q.size() - CALM_ITEMS);
            if (!calm && $urandom_range(0, 3) == 0) begin
                s_valid = 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge aclk);
            end
            cur_row = stim_q[i];
            s_data = stim_q[i].w;
            s_valid = 1'b1;
            @(posedge aclk);
            while (!s_ready) @(posedge aclk);
            @(negedge aclk);
        end
        s_valid = 1'b0;
        stim_done = 1'b1;
    end

    // Sink side: random stall bursts, plus one long hold-off to fill the queue
    int   stall_left = 0;
    logic hold_done = 1'b0;
    always @(negedge aclk) begin
        if (!hold_done && n_in >= 120) begin
            hold_done = 1'b1;
            stall_left = HOLD_CYCLES;
            m_ready = 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_ready = 1'b0;
        end else if (!calm && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 5);
            m_ready = 1'b0;
        end else begin
            m_ready = 1'b1;
        end
    end

    // Decode accepted words, then check result words against the oldest entry
    always @(posedge aclk) begin
        out_word_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                n_in++;
                unescape_step(cur_row.w);
                if (cur_row.typed) begin
                    want_q.push_back(cur_row.r);
                end else begin
                    for (int k = 0; k < step_n; k++) want_q.push_back(step_res[k]);
                end
            end
            if (m_valid && m_ready) begin
                if (want_q.size() == 0) begin
                    if (mismatches < 10)
                        $display("unexpected word: byte %h ev %0d err %0d last %0d",
                                 m_data.out_byte, m_data.event_res,
                                 m_data.error_code, m_data.last);
                    mismatches++;
                end else begin
                    want = want_q.pop_front();
                    if (m_data.out_byte !== want.out_byte
                        || m_data.event_res !== want.event_res
                        || m_data.error_code !== want.error_code
                        || m_data.last !== want.last) begin
                        if (mismatches < 10)
                            $display("mismatch: got byte %h ev %0d err %0d last %0d,",
                                     m_data.out_byte, m_data.event_res,
                                     m_data.error_code, m_data.last,
                                     " want byte %h ev %0d err %0d last %0d",
                                     want.out_byte, want.event_res,
                                     want.error_code, want.last);
                        mismatches++;
                    end
                end
            end
        end
    end

    // Drain and report
    initial begin
        wait (stim_done);
        while (want_q.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (mismatches == 0 && want_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2ms;
        $display("Test completed with failures");
        $finish;
    end

endmodule

/* files.f */
rtl/jsu_pkg.sv
rtl/jsu_front.sv
rtl/jsu_queue.sv
rtl/jsu_back.sv
rtl/json_string_unescape_utf8_top.sv
tb/json_string_unescape_utf8_top_tb.sv
